### rtl/svpwm_timing_with_overmod_limit_top_macros.svh
// ----------------------------------------------------------------------------
// svpwm assertion macros
// Shared concurrent assertion forms for the svpwm checker.
// ----------------------------------------------------------------------------
`ifndef SVPWM_TIMING_WITH_OVERMOD_LIMIT_TOP_MACROS_SVH
`define SVPWM_TIMING_WITH_OVERMOD_LIMIT_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define SVPWM_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("svpwm check failed");

// next-cycle implication, disabled during reset
`define SVPWM_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("svpwm check failed");

`endif

### rtl/svpwm_pkg.sv
// ----------------------------------------------------------------------------
// svpwm_pkg
// Types and constants shared by the svpwm timing block.
// ----------------------------------------------------------------------------
package svpwm_pkg;

	localparam logic [16:0] SQRT3_Q16   = 17'd113512;
	localparam logic [14:0] DUTY_CAP    = 15'd26214;
	localparam logic [15:0] PEAK_RESET  = 16'd1000;
	localparam logic [14:0] FRAC_RESET  = 15'd26214;

	localparam logic        REG_PEAK    = 1'b0;
	localparam logic        REG_FRAC    = 1'b1;

	localparam logic [4:0]  QBITS_NORM  = 5'd16;
	localparam logic [4:0]  QBITS_LIM   = 5'd29;

	localparam logic [2:0]  SECTOR_1    = 3'd1;
	localparam logic [2:0]  SECTOR_2    = 3'd2;
	localparam logic [2:0]  SECTOR_3    = 3'd3;
	localparam logic [2:0]  SECTOR_4    = 3'd4;
	localparam logic [2:0]  SECTOR_5    = 3'd5;
	localparam logic [2:0]  SECTOR_6    = 3'd6;

	// one classified item waiting for the divider
	typedef struct packed {
		logic [2:0]         sector;
		logic               zb;
		logic               lim;
		logic [15:0]        va;
		logic [15:0]        vb;
		logic [15:0]        peak;
		logic [30:0]        mq;
		logic [34:0]        dvsr;
		logic [62:0]        n1;
		logic [62:0]        n2;
		logic [62:0]        n3;
	} job_t;

endpackage

### rtl/svpwm_intf.sv
// ----------------------------------------------------------------------------
// svpwm interfaces
// Valid/ready channels for input words, result words and register writes.
// ----------------------------------------------------------------------------
interface svpwm_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] v_alpha;
	logic signed [15:0] v_beta;
	logic [15:0]        v_bus;
	modport source (output valid, v_alpha, v_beta, v_bus, input ready);
	modport sink   (input valid, v_alpha, v_beta, v_bus, output ready);
endinterface

interface svpwm_out_if;
	logic               valid;
	logic               ready;
	logic [2:0]         sector;
	logic               overmod;
	logic [15:0]        zero_time;
	logic [15:0]        first_time;
	logic [15:0]        second_time;
	logic [15:0]        u_compare;
	logic [15:0]        v_compare;
	logic [15:0]        w_compare;
	logic signed [15:0] limited_alpha;
	logic signed [15:0] limited_beta;
	modport source (output valid, sector, overmod, zero_time, first_time, second_time,
		u_compare, v_compare, w_compare, limited_alpha, limited_beta, input ready);
	modport sink   (input valid, sector, overmod, zero_time, first_time, second_time,
		u_compare, v_compare, w_compare, limited_alpha, limited_beta, output ready);
endinterface

interface svpwm_cfg_if;
	logic        valid;
	logic        ready;
	logic        addr;
	logic [15:0] data;
	modport source (output valid, addr, data, input ready);
	modport sink   (input valid, addr, data, output ready);
endinterface

### rtl/svpwm_front.sv
// ----------------------------------------------------------------------------
// svpwm_front
// Three-stage pipeline: projections, sector, limit test and divider operands.
// ----------------------------------------------------------------------------
module svpwm_front import svpwm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] v_alpha,
	input  logic signed [15:0] v_beta,
	input  logic [15:0]        v_bus,
	input  logic [15:0]        peak,
	input  logic [14:0]        frac,
	output logic               push,
	output job_t               push_data,
	input  logic               q_full
);

	logic               en;
	logic               valid_s1, valid_s2, valid_s3;
	logic signed [15:0] va_s1, vb_s1, va_s2, vb_s2;
	logic [15:0]        vbus_s1, vbus_s2, peak_s1, peak_s2;
	logic [14:0]        m_s1;
	logic signed [33:0] s_s1;
	logic signed [17:0] a3_s1;
	logic signed [33:0] s_c;
	logic signed [17:0] a3_c;
	logic [14:0]        m_c;
	logic signed [35:0] ab_c, bc_c, ca_c, p1_c, p2_c;
	logic [2:0]         sector_c, sector_s2;
	logic [33:0]        v1_s2, v2_s2;
	logic [34:0]        sum_s2;
	logic [30:0]        md_s2, mq_s2;
	logic [49:0]        pr1_c, pr2_c;
	logic [50:0]        pr3_c;
	logic               lim_c;
	job_t               job_c, job_s3;

	assign en       = !valid_s3 || !q_full;
	assign in_ready = en;
	assign push     = valid_s3 && !q_full;
	assign push_data = job_s3;

	assign s_c  = v_beta * $signed({1'b0, SQRT3_Q16});
	assign a3_c = {{2{v_alpha[15]}}, v_alpha} + {v_alpha[15], v_alpha, 1'b0};
	assign m_c  = (frac > DUTY_CAP) ? DUTY_CAP : frac;

	assign ab_c = $signed({{2{a3_s1[17]}}, a3_s1, 16'h0000}) - $signed({{2{s_s1[33]}}, s_s1});
	assign bc_c = $signed({s_s1[33], s_s1, 1'b0});
	assign ca_c = -(ab_c + bc_c);

	always_comb begin
		if (!ab_c[35]) begin
			if (!bc_c[35]) begin
				sector_c = SECTOR_1; p1_c = ab_c; p2_c = bc_c;
			end else if (!ca_c[35]) begin
				sector_c = SECTOR_5; p1_c = ca_c; p2_c = ab_c;
			end else begin
				sector_c = SECTOR_6; p1_c = -ca_c; p2_c = -bc_c;
			end
		end else begin
			if (bc_c[35] || bc_c == 36'sd0) begin
				sector_c = SECTOR_4; p1_c = -bc_c; p2_c = -ab_c;
			end else if (ca_c[35] || ca_c == 36'sd0) begin
				sector_c = SECTOR_2; p1_c = -ab_c; p2_c = -ca_c;
			end else begin
				sector_c = SECTOR_3; p1_c = bc_c; p2_c = ca_c;
			end
		end
	end

	// limit test and operand choice
	assign lim_c = (peak_s2 != 16'd0) && (vbus_s2 != 16'd0)
		&& ({sum_s2, 15'h0000} > {2'b00, md_s2, 17'h00000});
	assign pr1_c = v1_s2 * peak_s2;
	assign pr2_c = v2_s2 * peak_s2;
	assign pr3_c = sum_s2 * peak_s2;

	always_comb begin
		job_c.sector = sector_s2;
		job_c.zb     = (vbus_s2 == 16'd0);
		job_c.lim    = lim_c;
		job_c.va     = va_s2;
		job_c.vb     = vb_s2;
		job_c.peak   = peak_s2;
		job_c.mq     = mq_s2;
		if (lim_c) begin
			job_c.dvsr = sum_s2;
			job_c.n1   = {1'b0, v1_s2, 28'h0};
			job_c.n2   = {1'b0, v2_s2, 28'h0};
			job_c.n3   = {2'b00, md_s2, 30'h0};
		end else begin
			job_c.dvsr = {2'b00, vbus_s2, 17'h00000};
			job_c.n1   = {13'h0, pr1_c};
			job_c.n2   = {13'h0, pr2_c};
			job_c.n3   = {12'h0, pr3_c};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			va_s1     <= v_alpha;
			vb_s1     <= v_beta;
			vbus_s1   <= v_bus;
			peak_s1   <= peak;
			m_s1      <= m_c;
			s_s1      <= s_c;
			a3_s1     <= a3_c;
			va_s2     <= va_s1;
			vb_s2     <= vb_s1;
			vbus_s2   <= vbus_s1;
			peak_s2   <= peak_s1;
			sector_s2 <= sector_c;
			v1_s2     <= p1_c[33:0];
			v2_s2     <= p2_c[33:0];
			sum_s2    <= {1'b0, p1_c[33:0]} + {1'b0, p2_c[33:0]};
			md_s2     <= m_s1 * vbus_s1;
			mq_s2     <= m_s1 * peak_s1;
			job_s3    <= job_c;
		end
	end

endmodule

### rtl/svpwm_queue.sv
// ----------------------------------------------------------------------------
// svpwm_queue
// Short FIFO of classified items between the front and the divider.
// ----------------------------------------------------------------------------
module svpwm_queue import svpwm_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_data,
	input  logic pop,
	output job_t pop_data,
	output logic full,
	output logic empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign full     = (cnt_q == CW'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

### rtl/svpwm_back.sv
// ----------------------------------------------------------------------------
// svpwm_back
// Three-lane radix-2 divider, scaling products and compare assembly.
// ----------------------------------------------------------------------------
module svpwm_back import svpwm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  job_t               q_data,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         sector,
	output logic               overmod,
	output logic [15:0]        zero_time,
	output logic [15:0]        first_time,
	output logic [15:0]        second_time,
	output logic [15:0]        u_compare,
	output logic [15:0]        v_compare,
	output logic [15:0]        w_compare,
	output logic signed [15:0] limited_alpha,
	output logic signed [15:0] limited_beta
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_MUL  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0]  st_q;
	job_t        job_q;
	logic [4:0]  cnt_q;
	logic [35:0] rem1_q, rem2_q, rem3_q;
	logic [62:0] sh1_q, sh2_q, sh3_q;
	logic [28:0] quo1_q, quo2_q, quo3_q;
	logic [35:0] nr1_c, nr2_c, nr3_c;
	logic        b1_c, b2_c, b3_c;
	logic [15:0] t1_q, t2_q, la_q, lb_q;
	logic [16:0] used_q;
	logic [59:0] prod1_c, prod2_c;
	logic [16:0] mag_a_c, mag_b_c, sa_c, sb_c;
	logic [44:0] proda_c, prodb_c;
	logic [16:0] used_c;
	logic [15:0] t1_c, t2_c, la_c, lb_c;
	logic [15:0] t0_c, c0_c, c1_c, c2_c, cu_c, cv_c, cw_c;
	logic        fin;

	function automatic logic [36:0] div_step(input logic [35:0] rem, input logic nbit,
		input logic [34:0] dvsr);
		logic [35:0] t;
		t = {rem[34:0], nbit};
		if (t >= {1'b0, dvsr})
			return {t - {1'b0, dvsr}, 1'b1};
		return {t, 1'b0};
	endfunction

	assign {nr1_c, b1_c} = div_step(rem1_q, sh1_q[62], job_q.dvsr);
	assign {nr2_c, b2_c} = div_step(rem2_q, sh2_q[62], job_q.dvsr);
	assign {nr3_c, b3_c} = div_step(rem3_q, sh3_q[62], job_q.dvsr);

	assign pop = (st_q == ST_IDLE) && !q_empty;
	assign fin = (st_q == ST_FIN) && (!out_valid || out_ready);

	// limited-case products: active times and voltage scale
	assign prod1_c = job_q.mq * quo1_q;
	assign prod2_c = job_q.mq * quo2_q;
	assign mag_a_c = job_q.va[15] ? (17'd0 - {job_q.va[15], job_q.va}) : {1'b0, job_q.va};
	assign mag_b_c = job_q.vb[15] ? (17'd0 - {job_q.vb[15], job_q.vb}) : {1'b0, job_q.vb};
	assign proda_c = mag_a_c * quo3_q[27:0];
	assign prodb_c = mag_b_c * quo3_q[27:0];
	assign sa_c    = proda_c[44:28];
	assign sb_c    = prodb_c[44:28];

	always_comb begin
		if (job_q.zb) begin
			t1_c = '0; t2_c = '0; la_c = '0; lb_c = '0; used_c = '0;
		end else if (job_q.lim) begin
			t1_c   = prod1_c[58:43];
			t2_c   = prod2_c[58:43];
			la_c   = job_q.va[15] ? 16'(17'd0 - sa_c) : sa_c[15:0];
			lb_c   = job_q.vb[15] ? 16'(17'd0 - sb_c) : sb_c[15:0];
			used_c = 17'(({1'b0, job_q.mq} + 32'd32767) >> 15);
		end else begin
			t1_c   = quo1_q[15:0];
			t2_c   = quo2_q[15:0];
			la_c   = job_q.va;
			lb_c   = job_q.vb;
			used_c = {1'b0, quo3_q[15:0]} + {16'h0, (rem3_q != 36'h0)};
		end
	end

	assign t0_c = (used_q > {1'b0, job_q.peak}) ? 16'h0 : (job_q.peak - used_q[15:0]);
	assign c0_c = {1'b0, t0_c[15:1]};
	assign c1_c = c0_c + t1_q;
	assign c2_c = c1_c + t2_q;

	always_comb begin
		case (job_q.sector)
			SECTOR_1: begin cu_c = c0_c; cv_c = c1_c; cw_c = c2_c; end
			SECTOR_2: begin cv_c = c0_c; cu_c = c1_c; cw_c = c2_c; end
			SECTOR_3: begin cv_c = c0_c; cw_c = c1_c; cu_c = c2_c; end
			SECTOR_4: begin cw_c = c0_c; cv_c = c1_c; cu_c = c2_c; end
			SECTOR_5: begin cw_c = c0_c; cu_c = c1_c; cv_c = c2_c; end
			default:  begin cu_c = c0_c; cw_c = c1_c; cv_c = c2_c; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			cnt_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (fin)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (!q_empty) begin
						st_q  <= q_data.zb ? ST_MUL : ST_DIV;
						cnt_q <= (q_data.lim ? QBITS_LIM : QBITS_NORM) - 5'd1;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd0)
						st_q <= ST_MUL;
				end
				ST_MUL: st_q <= ST_FIN;
				ST_FIN: begin
					if (fin)
						st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q  <= q_data;
			quo1_q <= '0;
			quo2_q <= '0;
			quo3_q <= '0;
			if (q_data.lim) begin
				rem1_q <= 36'(q_data.n1 >> QBITS_LIM);
				rem2_q <= 36'(q_data.n2 >> QBITS_LIM);
				rem3_q <= 36'(q_data.n3 >> QBITS_LIM);
				sh1_q  <= q_data.n1 << 34;
				sh2_q  <= q_data.n2 << 34;
				sh3_q  <= q_data.n3 << 34;
			end else begin
				rem1_q <= 36'(q_data.n1 >> QBITS_NORM);
				rem2_q <= 36'(q_data.n2 >> QBITS_NORM);
				rem3_q <= 36'(q_data.n3 >> QBITS_NORM);
				sh1_q  <= q_data.n1 << 47;
				sh2_q  <= q_data.n2 << 47;
				sh3_q  <= q_data.n3 << 47;
			end
		end else if (st_q == ST_DIV) begin
			rem1_q <= nr1_c;
			rem2_q <= nr2_c;
			rem3_q <= nr3_c;
			sh1_q  <= {sh1_q[61:0], 1'b0};
			sh2_q  <= {sh2_q[61:0], 1'b0};
			sh3_q  <= {sh3_q[61:0], 1'b0};
			quo1_q <= {quo1_q[27:0], b1_c};
			quo2_q <= {quo2_q[27:0], b2_c};
			quo3_q <= {quo3_q[27:0], b3_c};
		end
		if (st_q == ST_MUL) begin
			t1_q   <= t1_c;
			t2_q   <= t2_c;
			la_q   <= la_c;
			lb_q   <= lb_c;
			used_q <= used_c;
		end
		if (fin) begin
			sector        <= job_q.sector;
			overmod       <= job_q.zb || job_q.lim;
			zero_time     <= t0_c;
			first_time    <= t1_q;
			second_time   <= t2_q;
			u_compare     <= cu_c;
			v_compare     <= cv_c;
			w_compare     <= cw_c;
			limited_alpha <= la_q;
			limited_beta  <= lb_q;
		end
	end

endmodule

### rtl/svpwm_timing_with_overmod_limit_top.sv
// ----------------------------------------------------------------------------
// svpwm_timing_with_overmod_limit_top
// Seven-segment space vector PWM timing with an overmodulation duty limit.
// ----------------------------------------------------------------------------
// A three-stage front pipeline takes one command word per cycle unless
// stalled, finds the sector, decides whether the duty limit applies and
// parks the word in a short queue. The back end runs three division lanes
// side by side, one quotient bit per cycle; an unlimited word runs
// QBITS_NORM steps, a limited one QBITS_LIM, and a zero bus voltage skips
// the divider. That divider loop sets the sustained rate. The front keeps
// accepting words until the queue is full and its last stage holds a word,
// and a finished result waits in the output register without holding up
// the next division. Register writes (peak count, duty fraction) are always
// ready and take effect on the next accepted word.
module svpwm_timing_with_overmod_limit_top import svpwm_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	svpwm_in_if.sink   din,
	svpwm_out_if.source dout,
	svpwm_cfg_if.sink  cfg
);

	logic [15:0] peak_q;
	logic [14:0] frac_q;
	logic        push, pop, q_full, q_empty;
	job_t        push_data, pop_data;

	// register port: always ready, write on handshake
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q <= PEAK_RESET;
			frac_q <= FRAC_RESET;
		end else if (cfg.valid) begin
			case (cfg.addr)
				REG_PEAK: peak_q <= cfg.data;
				REG_FRAC: frac_q <= cfg.data[14:0];
				default:  ;
			endcase
		end
	end

	// front: projections, sector, limit decision, divider operands
	svpwm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (din.valid),
		.in_ready  (din.ready),
		.v_alpha   (din.v_alpha),
		.v_beta    (din.v_beta),
		.v_bus     (din.v_bus),
		.peak      (peak_q),
		.frac      (frac_q),
		.push      (push),
		.push_data (push_data),
		.q_full    (q_full)
	);

	// decouple the front, one word per cycle when not stalled, from the iterative back end
	svpwm_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.full      (q_full),
		.empty     (q_empty)
	);

	// back: divide, scale, assemble compares, hold result for the sink
	svpwm_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_data        (pop_data),
		.pop           (pop),
		.out_valid     (dout.valid),
		.out_ready     (dout.ready),
		.sector        (dout.sector),
		.overmod       (dout.overmod),
		.zero_time     (dout.zero_time),
		.first_time    (dout.first_time),
		.second_time   (dout.second_time),
		.u_compare     (dout.u_compare),
		.v_compare     (dout.v_compare),
		.w_compare     (dout.w_compare),
		.limited_alpha (dout.limited_alpha),
		.limited_beta  (dout.limited_beta)
	);

endmodule

### rtl/svpwm_chk.sv
// ----------------------------------------------------------------------------
// svpwm_chk
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "svpwm_timing_with_overmod_limit_top_macros.svh"

module svpwm_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  sector,
	input logic        overmod,
	input logic [15:0] first_time,
	input logic [15:0] second_time,
	input logic [15:0] u_compare,
	input logic [15:0] v_compare,
	input logic [15:0] w_compare
);

	// hold a stalled result
	`SVPWM_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(u_compare) && $stable(sector))

	// without limiting, the compares of sector one rise without wrap
	`SVPWM_ASSERT_IMP(a_sec1_order, clk, arst_n, out_valid && !overmod && sector == 3'd1, u_compare <= v_compare && v_compare <= w_compare)

	// no active time means all phases switch together
	`SVPWM_ASSERT_IMP(a_zero_active, clk, arst_n, out_valid && first_time == 16'd0 && second_time == 16'd0, u_compare == v_compare && v_compare == w_compare)

endmodule

bind svpwm_timing_with_overmod_limit_top svpwm_chk u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (dout.valid),
	.out_ready   (dout.ready),
	.sector      (dout.sector),
	.overmod     (dout.overmod),
	.first_time  (dout.first_time),
	.second_time (dout.second_time),
	.u_compare   (dout.u_compare),
	.v_compare   (dout.v_compare),
	.w_compare   (dout.w_compare)
);
